// File: hdl/percpu_page_allocator_top_defines.svh
// Assertion macros of the page allocator, used by its sequencer
`ifndef PERCPU_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define PERCPU_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PCPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcpa assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcpa assertion failed");

`endif

// File: hdl/pcpa_pkg.sv
// Shared constants, codes and interface structs of the page allocator
package pcpa_pkg;

    // Sizing
    localparam int NUM_CPUS   = 8;
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int CPU_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int LINK_W    = 16;

    // Derived widths
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int SEL_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    // Empty-list marker; no page index reaches it
    localparam logic [LINK_W-1:0] LINK_EMPTY = '1;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_REG_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_LIMIT = 1'b1;
    localparam logic [CFG_W-1:0]     START_RESET   = 32'h0000_0000;
    localparam logic [CFG_W-1:0]     LIMIT_RESET   = 32'h8800_0000;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the accepted request beat
        logic check;   // evaluate free address checks
        logic pick;    // select a list and read its head link
        logic commit;  // update lists and load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_free;
    } t_sts;

endpackage

// File: hdl/pcpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pcpa_ctrl.sv
// Request sequencer and handshake control of the page allocator
`include "percpu_page_allocator_top_defines.svh"

module pcpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  pcpa_pkg::t_sts i_sts,
    output pcpa_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;

    // Decode commands from the current state
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.check  = (r_state == S_EXEC) && i_sts.is_free;
        o_cmd.pick   = (r_state == S_EXEC) && !i_sts.is_free;
        o_cmd.commit = (r_state == S_DONE) && slot_free;
    end

    // Next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // A blocked result holds the sequencer in its final state
    `PCPA_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n,
        (r_state == S_DONE) && r_out_valid && i_out_stall, r_state == S_DONE)
    // A new result beat appears only after a commit
    `PCPA_ASSERT_NOW(a_valid_from_commit, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state == S_DONE))
    // An accepted request beat always starts work
    `PCPA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, r_state == S_EXEC)

endmodule

// File: hdl/pcpa_dp.sv
// Datapath of the page allocator: config, list heads, link memory, result
module pcpa_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcpa_pkg::t_cmd                    i_cmd,
    output pcpa_pkg::t_sts                    o_sts,
    input  logic                              i_req_type,
    input  logic [pcpa_pkg::CPU_W-1:0]        i_cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0]       i_page_addr,
    input  logic                              i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcpa_pkg::CFG_W-1:0]        i_cfg_data,
    output logic [pcpa_pkg::STATUS_W-1:0]     o_status,
    output logic [pcpa_pkg::ADDR_W-1:0]       o_alloc_addr
);

    localparam int ADDR_W     = pcpa_pkg::ADDR_W;
    localparam int PAGE_SHIFT = pcpa_pkg::PAGE_SHIFT;
    localparam int PFN_W      = pcpa_pkg::PFN_W;
    localparam int IDX_W      = pcpa_pkg::IDX_W;
    localparam int SEL_W      = pcpa_pkg::SEL_W;
    localparam int LINK_W     = pcpa_pkg::LINK_W;
    localparam int NUM_CPUS   = pcpa_pkg::NUM_CPUS;

    // Configuration and derived page base
    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W-1:0] r_limit;
    logic [ADDR_W-1:0] r_base;
    logic              r_base_ok;
    logic [PFN_W:0]    base_sum;

    // List heads
    logic [LINK_W-1:0] r_heads [NUM_CPUS];

    // Captured request
    logic                         r_req_type;
    logic [pcpa_pkg::CPU_W-1:0]   r_cpu;
    logic [ADDR_W-1:0]            r_addr;

    // Check and pick results
    logic              r_chk_ok;
    logic [PFN_W-1:0]  r_diff;
    logic [SEL_W-1:0]  r_sel;
    logic              r_found;
    logic [IDX_W-1:0]  r_pop_idx;

    // Result register
    logic [pcpa_pkg::STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0]             r_alloc_addr;

    logic                cpu_ok;
    logic [SEL_W-1:0]    cpu_sel;
    logic [NUM_CPUS-1:0] mask;
    logic                own_ok;
    logic [SEL_W-1:0]    first_sel;
    logic [SEL_W-1:0]    pick_sel;
    logic [LINK_W-1:0]   pick_head;
    logic                chk_ok;
    logic                in_cap;
    logic                free_ok;
    logic                ram_we;
    logic [LINK_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]   pop_addr;

    // Round region start up to a page boundary; carry out means no base
    assign base_sum = {1'b0, r_start[ADDR_W-1:PAGE_SHIFT]}
                    + (PFN_W+1)'(|r_start[PAGE_SHIFT-1:0]);

    assign cpu_ok  = 32'(r_cpu) < NUM_CPUS;
    assign cpu_sel = SEL_W'(r_cpu);

    // Find own non-empty list, else the lowest non-empty list
    always_comb begin
        first_sel = '0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            mask[c] = (r_heads[c] != pcpa_pkg::LINK_EMPTY);
        end
        for (int c = NUM_CPUS - 1; c >= 0; c--) begin
            if (mask[c]) begin
                first_sel = SEL_W'(c);
            end
        end
    end

    assign own_ok    = cpu_ok && mask[cpu_sel];
    assign pick_sel  = own_ok ? cpu_sel : first_sel;
    assign pick_head = r_heads[pick_sel];

    // Free address checks
    assign chk_ok = r_base_ok && cpu_ok
                 && (r_addr[PAGE_SHIFT-1:0] == '0)
                 && (r_addr >= r_start)
                 && (r_addr < r_limit);

    assign in_cap  = 32'(r_diff) < pcpa_pkg::NUM_PAGES;
    assign free_ok = r_chk_ok && in_cap;
    assign ram_we  = i_cmd.commit && (r_req_type == pcpa_pkg::REQ_FREE) && free_ok;

    assign pop_addr = r_base + (ADDR_W'(r_pop_idx) << PAGE_SHIFT);

    // Link memory: one next pointer per page
    pcpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (pcpa_pkg::NUM_PAGES)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_diff[IDX_W-1:0]),
        .i_wdata (r_heads[cpu_sel]),
        .i_re    (i_cmd.pick),
        .i_raddr (pick_head[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Config registers and list heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= pcpa_pkg::START_RESET;
            r_limit <= pcpa_pkg::LIMIT_RESET;
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_heads[c] <= pcpa_pkg::LINK_EMPTY;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pcpa_pkg::CFG_REG_START: r_start <= i_cfg_data;
                    pcpa_pkg::CFG_REG_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_heads[cpu_sel] <= LINK_W'(r_diff[IDX_W-1:0]);
            end else if (i_cmd.commit && (r_req_type == pcpa_pkg::REQ_ALLOC) && r_found) begin
                r_heads[r_sel] <= ram_rdata;
            end
        end
    end

    // Request capture, check/pick stage and result register
    always_ff @(posedge i_clk) begin
        r_base    <= {base_sum[PFN_W-1:0], {PAGE_SHIFT{1'b0}}};
        r_base_ok <= !base_sum[PFN_W];
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_cpu      <= i_cpu_id;
            r_addr     <= i_page_addr;
        end
        if (i_cmd.check) begin
            r_chk_ok <= chk_ok;
            r_diff   <= r_addr[ADDR_W-1:PAGE_SHIFT] - r_base[ADDR_W-1:PAGE_SHIFT];
        end
        if (i_cmd.pick) begin
            r_sel     <= pick_sel;
            r_found   <= |mask;
            r_pop_idx <= pick_head[IDX_W-1:0];
        end
        if (i_cmd.commit) begin
            if (r_req_type == pcpa_pkg::REQ_FREE) begin
                r_status     <= free_ok ? pcpa_pkg::ST_OK : pcpa_pkg::ST_BADADDR;
                r_alloc_addr <= '0;
            end else if (r_found) begin
                r_status     <= pcpa_pkg::ST_OK;
                r_alloc_addr <= pop_addr;
            end else begin
                r_status     <= pcpa_pkg::ST_OOM;
                r_alloc_addr <= '0;
            end
        end
    end

    assign o_sts.is_free = (r_req_type == pcpa_pkg::REQ_FREE);
    assign o_status      = r_status;
    assign o_alloc_addr  = r_alloc_addr;

endmodule

// File: hdl/percpu_page_allocator_top.sv
// A request beat is captured, then checked (free) or used to pick a list
// and read its head link from the link memory (alloc), then committed to
// the result register; no new request is accepted before that commit.
// A waiting result does not block acceptance until the next result is due.
// Reset (synchronous, active low) empties all lists and restores the region
// registers; the link memory is not cleared and needs no clearing pass.
module percpu_page_allocator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [pcpa_pkg::CPU_W-1:0]        i_cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0]       i_page_addr,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pcpa_pkg::STATUS_W-1:0]     o_status,
    output logic [pcpa_pkg::ADDR_W-1:0]       o_alloc_addr,
    input  logic                              i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcpa_pkg::CFG_W-1:0]        i_cfg_data
);

    pcpa_pkg::t_cmd cmd;
    pcpa_pkg::t_sts sts;

    // Sequencer
    pcpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Lists, link memory and result
    pcpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_cpu_id     (i_cpu_id),
        .i_page_addr  (i_page_addr),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_status     (o_status),
        .o_alloc_addr (o_alloc_addr)
    );

endmodule
